### sv/assert_macros.svh
// Assertion macros shared by the moving-average RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sma_pkg.sv
// Shared constants, types and state encoding for the moving-average block.
// No dependencies.
`timescale 1ns / 1ps

package sma_pkg;

   localparam int MAX_WINDOW    = 1024;
   localparam int SAMPLE_BITS   = 16;
   localparam int AVG_BITS      = 24;
   localparam int FRAC_BITS     = 8;
   localparam int PTR_BITS      = $clog2(MAX_WINDOW);
   localparam int WIN_BITS      = PTR_BITS + 1;
   localparam int SUM_BITS      = SAMPLE_BITS + PTR_BITS;
   localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);
   localparam int WINDOW_RESET  = 128;

   // APB register map
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [0:0] CSR_WINDOW_IDX = 1'b0;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [AVG_BITS-1:0]    average_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV
   } sma_state_type;

endpackage

### sv/sma_chan_if.sv
// Valid/ready channel interfaces for sample input and average output.
// Depends on sma_pkg.
`timescale 1ns / 1ps

interface sma_req_if;
   import sma_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface sma_rsp_if;
   import sma_pkg::*;
   logic        valid;
   logic        ready;
   average_type average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

### sv/sma_div.sv
// Restoring divider, one quotient bit per cycle (unsigned dividend / window).
// Depends on sma_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sma_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [sma_pkg::DIVIDEND_BITS-1:0]    dividend,
   input  logic [sma_pkg::WIN_BITS-1:0]         divisor,
   output logic                                 busy,
   output logic                                 done,
   output logic [sma_pkg::DIVIDEND_BITS-1:0]    quotient
);
   import sma_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WIN_BITS-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;

   logic [WIN_BITS:0]        shifted;
   logic [WIN_BITS:0]        diff;
   logic                     qbit;

   // one compare/subtract step
   assign shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign qbit    = ~diff[WIN_BITS];

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[WIN_BITS-1:0] : shifted[WIN_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   `SMA_ASSERT_NOW(a_div_not_both, clock, reset, 1'b1, !(busy_ff && done_ff), "divider busy and done")
   `SMA_ASSERT_NOW(a_div_rem_bound, clock, reset, busy_ff, rem_ff < divisor, "remainder not below divisor")
   `SMA_ASSERT_NOW(a_div_cnt_bound, clock, reset, busy_ff, cnt_ff < DIV_CNT_BITS'(DIVIDEND_BITS), "step count overrun")

endmodule

### sv/simple_moving_average_core.sv
// Boxcar moving average over the last window_size signed samples, 8 fraction bits.
// Depends on sma_pkg, sma_chan_if, sma_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Transfer when          Payload
// req_ch    in         valid && ready         sample  (s16)
// rsp_ch    out        valid && ready         average (s24, Q.8)
// csr_*     in (APB)   psel&penable&pwrite    window_size at byte 0 (11 bits)
//
// A sample that only fills the window is taken with the block staying idle.
// A sample that yields an average keeps req ready low through 34 divider
// steps, one quotient bit each for the 34-bit scaled sum, and then the load
// of the output register, after which the block returns to idle.
// A full output register holds the block in the divide state and stalls the input.
// A new sample is taken while the last average still waits on the output.
// Reset is synchronous; the sample ring needs no clearing pass.

module simple_moving_average_core (
   input  logic                                clock,
   input  logic                                reset,
   sma_req_if.sink                             req_ch,
   sma_rsp_if.source                           rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sma_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [sma_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [sma_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import sma_pkg::*;

   // ---------------- state ----------------
   sma_state_type            state_ff, state_in;
   logic [WIN_BITS-1:0]      window_ff, window_in;
   logic [PTR_BITS-1:0]      wp_ff, wp_in;
   logic [WIN_BITS-1:0]      fill_ff, fill_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic                     neg_ff, neg_in;
   logic [PTR_BITS-1:0]      oldest_ff, oldest_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [AVG_BITS-1:0]      rsp_avg_ff, rsp_avg_in;

   // sample ring, registered read port
   logic [SAMPLE_BITS-1:0]   ring_mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0]   rd_data_ff;

   // ---------------- control ----------------
   logic                     accept;
   logic                     csr_wr;
   logic                     window_wr;
   logic                     fill_full;
   logic                     rsp_free;
   logic                     rsp_load;
   logic                     div_start;
   logic                     div_busy;
   logic                     div_done;
   logic                     req_ready;
   logic [WIN_BITS-1:0]      weff;
   logic [SUM_BITS-1:0]      sample_ext;
   logic [SUM_BITS-1:0]      old_ext;
   logic [SUM_BITS-1:0]      sum_new;
   logic [SUM_BITS-1:0]      sum_mag;
   logic [DIVIDEND_BITS-1:0] dividend;
   logic [DIVIDEND_BITS-1:0] quotient;
   logic [AVG_BITS-1:0]      quo_trunc;
   logic [WIN_BITS-1:0]      oldest_wide;

   // Window clamped to [1, MAX_WINDOW]
   always_comb begin
      if (window_ff == '0) begin
         weff = WIN_BITS'(1);
      end else if (window_ff > WIN_BITS'(MAX_WINDOW)) begin
         weff = WIN_BITS'(MAX_WINDOW);
      end else begin
         weff = window_ff;
      end
   end

   assign accept    = req_ch.valid && req_ready;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign window_wr = csr_wr &&
                      (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_WINDOW_IDX);
   assign fill_full = (fill_ff == weff - 1'b1);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   // Sum after adding the new sample; its magnitude, scaled by 256, feeds the divider
   assign sample_ext = {{(SUM_BITS-SAMPLE_BITS){req_ch.sample[SAMPLE_BITS-1]}},
                        req_ch.sample};
   assign old_ext    = {{(SUM_BITS-SAMPLE_BITS){rd_data_ff[SAMPLE_BITS-1]}},
                        rd_data_ff};
   assign sum_new    = sum_ff + sample_ext;
   assign sum_mag    = sum_new[SUM_BITS-1] ? (~sum_new + 1'b1) : sum_new;
   assign dividend   = {sum_mag, {FRAC_BITS{1'b0}}};

   // Oldest entry of the window: wp - (w - 1), modulo ring size
   assign oldest_wide = {1'b0, wp_ff} + 1'b1 - weff;

   // Quotient magnitude tops out at 2^23, so the low 24 bits carry it
   assign quo_trunc = quotient[AVG_BITS-1:0];

   // ---------------- FSM: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && fill_full) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done && rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- FSM: outputs ----------------
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            div_start = accept && fill_full;
         end
         ST_DIV: begin
            rsp_load = div_done && rsp_free;
         end
         default: ;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      window_in    = window_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      oldest_in    = oldest_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (window_wr) begin
         // restart filling; ring and write pointer are kept
         window_in = csr_pwdata[WIN_BITS-1:0];
         fill_in   = '0;
         sum_in    = '0;
      end else if (accept) begin
         wp_in  = wp_ff + 1'b1;
         sum_in = sum_new;
         if (!fill_full) begin
            fill_in = fill_ff + 1'b1;
         end else begin
            neg_in    = sum_new[SUM_BITS-1];
            oldest_in = oldest_wide[PTR_BITS-1:0];
         end
      end else if (rsp_load) begin
         // average goes out, oldest sample leaves the window
         rsp_valid_in = 1'b1;
         rsp_avg_in   = neg_ff ? (~quo_trunc + 1'b1) : quo_trunc;
         sum_in       = sum_ff - old_ext;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WIN_BITS'(WINDOW_RESET);
         wp_ff        <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff     <= neg_in;
      oldest_ff  <= oldest_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   // Ring: write on every accepted sample. The read of the oldest entry runs
   // during the divide, after the write, so a window of one sees the new sample.
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[wp_ff] <= req_ch.sample;
      end
      rd_data_ff <= ring_mem[oldest_ff];
   end

   // ---------------- shared divider ----------------
   sma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (weff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---------------- ports ----------------
   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.average = rsp_avg_ff;
   assign csr_pready     = 1'b1;
   assign csr_prdata     = (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_WINDOW_IDX) ?
                           CSR_DATA_BITS'(window_ff) : '0;

   // ---------------- checks ----------------
   `SMA_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff < weff, "fill count beyond window")
   `SMA_ASSERT_NEXT(a_div_launch, clock, reset, div_start, (state_ff == ST_DIV) && div_busy, "divide not launched")
   `SMA_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE), "average not presented")

endmodule

### sim/tb.sv
// Self-checking testbench for simple_moving_average_core: boxcar average of signed samples.
// Depends on sma_pkg, sma_chan_if and the RTL top; predicts each average on sample transfer.
`timescale 1ns / 1ps

module tb;
   import sma_pkg::*;

   // Cycles without any transfer before the run is declared hung. The slowest legal quiet
   // stretch is the long output hold plus one divide plus a sender gap, well under this.
   localparam int unsigned STALL_LIMIT  = 4000;
   // An average needs 34 divider steps and then the load of the output register;
   // wait a bit longer before touching the register.
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned RANDOM_ITEMS  = 620;

   localparam logic [CSR_ADDR_BITS-1:0] WINDOW_ADDR = CSR_ADDR_BITS'(4 * CSR_WINDOW_IDX);
   localparam logic [WIN_BITS-1:0]      WINDOW_REG_MAX = '1;
   localparam sample_type               SAMPLE_MAX = 16'sh7FFF;
   localparam sample_type               SAMPLE_MIN = 16'sh8000;

   logic clock;
   logic reset;

   sma_req_if req_ch ();
   sma_rsp_if rsp_ch ();

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   simple_moving_average_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Window predictor: its own copy of the ring, position, fill and sum.
   // ------------------------------------------------------------------------
   sample_type          history [MAX_WINDOW];
   logic [PTR_BITS-1:0] next_slot;
   logic [WIN_BITS-1:0] window_reg;
   int unsigned         samples_held;
   longint              window_total;
   average_type         pending_averages [$];

   int unsigned mismatch_count = 0;
   int unsigned burst_left     = 0;
   int unsigned hold_requests  = 0;

   // Register value 0 behaves as 1, anything past the ring depth as the full ring.
   function automatic int unsigned active_window();
      if (window_reg == 0)
         return 1;
      if (window_reg > MAX_WINDOW)
         return MAX_WINDOW;
      return 32'(window_reg);
   endfunction

   // Book one accepted sample; queues an average once the window is full.
   function automatic void advance_window(input sample_type s);
      int unsigned w;
      int unsigned oldest;
      longint      scaled;
      w = active_window();
      history[next_slot] = s;
      oldest = (int'(next_slot) + MAX_WINDOW - (int'(w) - 1)) % MAX_WINDOW;
      next_slot = next_slot + 1'b1;
      window_total = window_total + s;
      if (samples_held < w - 1) begin
         samples_held++;
         return;
      end
      // Signed division truncates toward zero, as the hardware does.
      scaled = window_total * (longint'(1) << FRAC_BITS);
      pending_averages.insert(pending_averages.size(), average_type'(scaled / longint'(w)));
      window_total = window_total - history[oldest];
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return sample_type'(int'($urandom_range(0, 8)) - 4);   // truncation near zero
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic note_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns: %s", $time, text);
   endtask

   // ------------------------------------------------------------------------
   // Sample sender. Works in bursts; between bursts valid drops for a random
   // gap. valid is never lowered and raised within one edge.
   // ------------------------------------------------------------------------
   task automatic send_sample(input sample_type s);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // Mostly short bursts, now and then a long run with no idling at all.
         burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      advance_window(s);
      burst_left--;
   endtask

   // Stop offering and wait until every predicted average has been taken,
   // then let the divider go quiet before anything touches the register.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup, access until pready, then an idle state with psel low,
   // so the next transfer never reassigns psel on the same edge.
   task automatic csr_transfer(input bit is_write, input logic [CSR_DATA_BITS-1:0] wdata,
                               output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= WINDOW_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Window change: only with the block idle. Restarts filling; ring is kept.
   task automatic set_window(input logic [WIN_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] wide;
      logic [CSR_DATA_BITS-1:0] readback;
      wide = CSR_DATA_BITS'(value);
      drain_results();
      csr_transfer(1'b1, wide, readback);
      window_reg   = value;
      samples_held = 0;
      window_total = 0;
      csr_transfer(1'b0, '0, readback);
      if (readback !== wide)
         note_mismatch($sformatf("window_size readback: expected %0d, got %0d",
                                 wide, readback));
   endtask

   // ------------------------------------------------------------------------
   // Average receiver and checker. ready follows a pattern whose mode is redrawn
   // at random intervals; a hold request forces ready low for a long stretch
   // counted here.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned run_left;
      int unsigned hold_left;
      int unsigned holds_served;
      bit          stalled;
      bit          take;
      average_type want;
      mode_left    = 0;
      run_left     = 0;
      hold_left    = 0;
      holds_served = 0;
      stalled      = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_averages.size() == 0) begin
               note_mismatch($sformatf("average %0d with nothing pending", rsp_ch.average));
            end else begin
               want = pending_averages.pop_front();
               if (rsp_ch.average !== want)
                  note_mismatch($sformatf("average: expected %0d, got %0d",
                                          want, rsp_ch.average));
            end
         end
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            case (mode)
               0: take = 1'b1;                              // always ready
               1: take = (mode_left % 2) == 0;              // alternating take and stall
               2: take = $urandom_range(0, 9) < 7;          // light random stalls
               default: begin                               // runs of stall / take
                  if (run_left == 0) begin
                     run_left = $urandom_range(1, 30);
                     stalled  = ~stalled;
                  end
                  run_left--;
                  take = !stalled;
               end
            endcase
         end
         rsp_ch.ready <= take && !reset;
      end
   end

   // Watchdog: ends the run if nothing moves on either channel for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("simple_moving_average_core: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Register comes out of reset at the default window.
   task automatic test_window_reset_value();
      logic [CSR_DATA_BITS-1:0] readback;
      logic [CSR_DATA_BITS-1:0] wide;
      wide = WINDOW_RESET;
      csr_transfer(1'b0, '0, readback);
      if (readback !== wide)
         note_mismatch($sformatf("window_size after reset: expected %0d, got %0d",
                                 wide, readback));
   endtask

   // Window of one: every sample gives sample * 256, including both extremes.
   task automatic test_unit_window();
      set_window(WIN_BITS'(1));
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(sample_type'(0));
      send_sample(sample_type'(-1));
      send_sample(sample_type'(1));
      send_sample(sample_type'(16'h5555));
      send_sample(sample_type'(16'hAAAA));
   endtask

   // A zero register value must act as a window of one.
   task automatic test_zero_window();
      set_window(WIN_BITS'(0));
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(sample_type'(-3));
   endtask

   // Window of three: full-scale sums both ways, then small negative sums that
   // must truncate toward zero rather than down.
   task automatic test_truncation();
      set_window(WIN_BITS'(3));
      repeat (3) send_sample(SAMPLE_MAX);
      repeat (3) send_sample(SAMPLE_MIN);
      send_sample(sample_type'(-1));
      send_sample(sample_type'(1));
      send_sample(sample_type'(-2));
      send_sample(sample_type'(0));
   endtask

   // Random phases over many window sizes; some phases stop mid-fill so the
   // next write has to restart filling.
   task automatic test_random_windows();
      int unsigned         sent;
      int unsigned         count;
      logic [WIN_BITS-1:0] value;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       value = WIN_BITS'($urandom_range(1, 4));
            1, 2:    value = WIN_BITS'($urandom_range(5, 32));
            3:       value = WIN_BITS'($urandom_range(33, 160));
            default: value = WIN_BITS'($urandom_range(2, 12));
         endcase
         set_window(value);
         if ($urandom_range(0, 5) == 0)
            count = $urandom_range(0, value - 1);
         else
            count = value + $urandom_range(4, 60);
         repeat (count) send_sample(pick_sample());
         sent += count;
      end
   endtask

   // All-ones register clamps to the full ring. Filling with the most negative
   // sample drives the running sum to its lower limit; the ring also wraps.
   task automatic test_full_window();
      set_window(WINDOW_REG_MAX);
      repeat (MAX_WINDOW + 6) send_sample(SAMPLE_MIN);
      repeat (20) send_sample(pick_sample());
   endtask

   // Receiver holds off for a long time while the sender keeps offering, so
   // the block fills and stalls its input; then the sender waits for all.
   task automatic test_output_backpressure();
      set_window(WIN_BITS'(3));
      repeat (6) send_sample(pick_sample());
      hold_requests++;
      repeat (30) send_sample(pick_sample());
      drain_results();
   endtask

   initial begin
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      reset         <= 1'b1;
      foreach (history[i]) history[i] = '0;
      next_slot    = '0;
      window_reg   = WINDOW_RESET;
      samples_held = 0;
      window_total = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_window_reset_value();
      test_unit_window();
      test_zero_window();
      test_truncation();
      test_random_windows();
      test_full_window();
      test_output_backpressure();

      drain_results();
      if (pending_averages.size() != 0)
         note_mismatch($sformatf("%0d averages never arrived", pending_averages.size()));
      if (mismatch_count == 0)
         $display("simple_moving_average_core: match");
      else
         $display("simple_moving_average_core: mismatch");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/sma_pkg.sv
sv/sma_chan_if.sv
sv/sma_div.sv
sv/simple_moving_average_core.sv
sim/tb.sv
